[design/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    // default store depth
    localparam int unsigned MAX_ENTRIES_DEFAULT = 16;

    // word fields
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;

    // configuration
    localparam int unsigned CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic        REG_CAPACITY = 1'b0;

    // returned by a get that misses
    localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

    typedef enum logic [2:0] {
        OP_GET_MISS,
        OP_GET_HIT,
        OP_PUT_HIT,
        OP_EVICT,
        OP_INSERT,
        OP_PUT_SKIP
    } op_t;

    typedef struct packed {
        logic load_item;
        logic load_search;
        logic load_result;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic is_put;
        logic hit;
        logic need_evict;
        logic lru_found;
        logic free_found;
    } status_t;

endpackage

`default_nettype wire

[design/lkv_datapath.sv]
// ----------------------------------------------------------------------------
// lkv_datapath
// entry store, parallel key match, recency ranks and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_datapath #(
    parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lkv_pkg::cmd_t                     cmd,
    output lkv_pkg::status_t                       status,
    input  wire logic [lkv_pkg::CAP_W-1:0]         capacity,
    input  wire logic                              mode,
    input  wire logic signed [lkv_pkg::KEY_W-1:0]  lookup_key,
    input  wire logic signed [lkv_pkg::VALUE_W-1:0] write_value,
    output logic                                   found,
    output logic signed [lkv_pkg::VALUE_W-1:0]     read_value,
    output logic                                   evicted
);

    localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

    typedef enum logic [1:0] {
        RES_VALUE,
        RES_MISS,
        RES_ZERO
    } res_kind_t;

    // item registers
    logic                          mode_reg;
    logic [lkv_pkg::KEY_W-1:0]     item_key_reg;
    logic [lkv_pkg::VALUE_W-1:0]   item_val_reg;

    // store
    logic [lkv_pkg::KEY_W-1:0]     key_reg   [MAX_ENTRIES];
    logic [lkv_pkg::VALUE_W-1:0]   value_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]        valid_reg, valid_next;
    logic [IW-1:0]                 rank_reg  [MAX_ENTRIES];
    logic [IW-1:0]                 rank_next [MAX_ENTRIES];
    logic [CW-1:0]                 count_reg, count_next;

    // search results
    logic [MAX_ENTRIES-1:0]        match, lru_match;
    logic                          hit_c, lru_c, free_c;
    logic [IW-1:0]                 hit_idx_c, lru_idx_c, free_idx_c, hit_rank_c;
    logic [CMPW-1:0]               eff_cap, count_ext, cap_ext;
    logic                          need_evict_c;

    logic                          hit_reg, lru_found_reg, free_found_reg, need_evict_reg;
    logic [IW-1:0]                 hit_idx_reg, lru_idx_reg, free_idx_reg, hit_rank_reg;

    // update
    logic [IW-1:0]                 tgt;
    logic [CW-1:0]                 thr;
    logic                          promote_en, mem_we, mem_re, key_we;

    // result
    logic                          found_reg, evicted_reg;
    res_kind_t                     kind_reg;
    logic [lkv_pkg::VALUE_W-1:0]   rd_data_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg     <= mode;
            item_key_reg <= lookup_key;
            item_val_reg <= write_value;
        end
    end

    // parallel match against every slot
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match[i]     = valid_reg[i] && (key_reg[i] == item_key_reg);
            lru_match[i] = valid_reg[i] && (CW'(rank_reg[i]) == count_reg - 1'b1);
        end
    end

    always_comb
    begin
        hit_c      = 1'b0;
        lru_c      = 1'b0;
        free_c     = 1'b0;
        hit_idx_c  = '0;
        lru_idx_c  = '0;
        free_idx_c = '0;
        hit_rank_c = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_c     = 1'b1;
                hit_idx_c = IW'(i);
            end
            if (lru_match[i])
            begin
                lru_c     = 1'b1;
                lru_idx_c = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_c     = 1'b1;
                free_idx_c = IW'(i);
            end
        end
        // keys are unique among valid slots, so at most one match
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_rank_c = hit_rank_c | (match[i] ? rank_reg[i] : '0);
        end
    end

    // capacity clamped to one through the store depth
    always_comb
    begin
        cap_ext   = CMPW'(capacity);
        count_ext = CMPW'(count_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_ext > CMPW'(MAX_ENTRIES))
        begin
            eff_cap = CMPW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        need_evict_c = (count_ext >= eff_cap);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_search)
        begin
            hit_reg        <= hit_c;
            hit_idx_reg    <= hit_idx_c;
            hit_rank_reg   <= hit_rank_c;
            lru_found_reg  <= lru_c;
            lru_idx_reg    <= lru_idx_c;
            free_found_reg <= free_c;
            free_idx_reg   <= free_idx_c;
            need_evict_reg <= need_evict_c;
        end
    end

    assign status = '{
        is_put:     mode_reg,
        hit:        hit_reg,
        need_evict: need_evict_reg,
        lru_found:  lru_found_reg,
        free_found: free_found_reg
    };

    // target slot and aging threshold
    always_comb
    begin
        case (cmd.op)
            lkv_pkg::OP_EVICT:
            begin
                tgt = lru_idx_reg;
                thr = count_reg - 1'b1;
            end
            lkv_pkg::OP_INSERT:
            begin
                tgt = free_idx_reg;
                thr = count_reg;
            end
            default:
            begin
                tgt = hit_idx_reg;
                thr = CW'(hit_rank_reg);
            end
        endcase
    end

    assign promote_en = cmd.load_result && (cmd.op == lkv_pkg::OP_GET_HIT
                        || cmd.op == lkv_pkg::OP_PUT_HIT || cmd.op == lkv_pkg::OP_EVICT
                        || cmd.op == lkv_pkg::OP_INSERT);
    assign key_we     = cmd.load_result && (cmd.op == lkv_pkg::OP_EVICT
                        || cmd.op == lkv_pkg::OP_INSERT);
    assign mem_we     = key_we || (cmd.load_result && cmd.op == lkv_pkg::OP_PUT_HIT);
    assign mem_re     = cmd.load_result && (cmd.op == lkv_pkg::OP_GET_HIT);

    // move to front: younger valid slots age by one
    always_comb
    begin
        rank_next  = rank_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        if (promote_en)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (valid_reg[i] && (CW'(rank_reg[i]) < thr))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            rank_next[tgt] = '0;
            if (cmd.op == lkv_pkg::OP_INSERT)
            begin
                valid_next[tgt] = 1'b1;
                count_next      = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_reg[tgt] <= item_key_reg;
        end
    end

    // value memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[tgt] <= item_val_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= value_mem[tgt];
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            found_reg   <= (cmd.op == lkv_pkg::OP_GET_HIT) || (cmd.op == lkv_pkg::OP_PUT_HIT);
            evicted_reg <= (cmd.op == lkv_pkg::OP_EVICT);
            case (cmd.op)
                lkv_pkg::OP_GET_HIT:  kind_reg <= RES_VALUE;
                lkv_pkg::OP_GET_MISS: kind_reg <= RES_MISS;
                default:              kind_reg <= RES_ZERO;
            endcase
        end
    end

    assign found   = found_reg;
    assign evicted = evicted_reg;

    always_comb
    begin
        case (kind_reg)
            RES_VALUE: read_value = rd_data_reg;
            RES_MISS:  read_value = lkv_pkg::MISS_VALUE;
            default:   read_value = '0;
        endcase
    end

    // fill count tracks the valid bits
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == count_reg)
        else $error("entry count differs from number of valid slots");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above store depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_result && cmd.op == lkv_pkg::OP_INSERT)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not add an entry");

endmodule

`default_nettype wire

[design/lkv_controller.sv]
// ----------------------------------------------------------------------------
// lkv_controller
// sequencer for search and update of one word at a time
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire lkv_pkg::status_t status,
    output lkv_pkg::cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   in_fire;

    assign in_ready = (state_reg == ST_IDLE) || (state_reg == ST_UPDATE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // operation picked from the registered search
    always_comb
    begin
        cmd.load_item   = in_fire;
        cmd.load_search = (state_reg == ST_SEARCH);
        cmd.load_result = (state_reg == ST_UPDATE);
        if (!status.is_put)
        begin
            cmd.op = status.hit ? lkv_pkg::OP_GET_HIT : lkv_pkg::OP_GET_MISS;
        end
        else if (status.hit)
        begin
            cmd.op = lkv_pkg::OP_PUT_HIT;
        end
        else if (status.need_evict && status.lru_found)
        begin
            cmd.op = lkv_pkg::OP_EVICT;
        end
        else if (status.free_found)
        begin
            cmd.op = lkv_pkg::OP_INSERT;
        end
        else
        begin
            cmd.op = lkv_pkg::OP_PUT_SKIP;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (out_free)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                out_valid_next = 1'b1;
                state_next     = in_valid ? ST_SEARCH : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_update_presents: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> out_valid_reg)
        else $error("update finished without a result word");

endmodule

`default_nettype wire

[design/lru_key_value_cache_core.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// a word passes the search state, then the update state, which registers its
// result; search waits while a result is untaken; update takes the next word
// the search compares all keys in parallel; the update moves ranks and writes
// reset: store empty, all ranks zero, capacity 16; no clearing pass needed
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_core #(
    parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input words
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  mode,
    input  wire logic signed [lkv_pkg::KEY_W-1:0]      lookup_key,
    input  wire logic signed [lkv_pkg::VALUE_W-1:0]    write_value,
    // result words
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       found,
    output logic signed [lkv_pkg::VALUE_W-1:0]         read_value,
    output logic                                       evicted,
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [lkv_pkg::CFG_ADDR_W-1:0]        paddr,
    input  wire logic [lkv_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [lkv_pkg::CFG_DATA_W-1:0]             prdata,
    output logic                                       pready
);

    lkv_pkg::cmd_t    cmd;
    lkv_pkg::status_t status;

    logic [lkv_pkg::CAP_W-1:0] capacity_reg;
    logic                      cfg_write;

    // register index sits at bit 2 of the byte address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // capacity register, only index zero exists; other writes fall away
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkv_pkg::CAP_RESET;
        end
        else if (cfg_write && (paddr[2] == lkv_pkg::REG_CAPACITY))
        begin
            capacity_reg <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lkv_pkg::REG_CAPACITY)
        begin
            prdata = lkv_pkg::CFG_DATA_W'(capacity_reg);
        end
    end

    // sequencer: idle, search, update; accepts the next word during update
    lkv_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // store, match, ranks and result register
    lkv_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .capacity    (capacity_reg),
        .mode        (mode),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .found       (found),
        .read_value  (read_value),
        .evicted     (evicted)
    );

endmodule

`default_nettype wire
